>>> design/lsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsl_pkg: shared types and constants for the two-channel lux calculator
// Payload structs, register codes, widths and the piecewise-linear
// coefficient tables for both package variants.
// ----------------------------------------------------------------------------
package lsl_pkg;

    // field and datapath widths
    localparam int CNT_W      = 16;
    localparam int SCALE_W    = 20;
    localparam int PROD_W     = CNT_W + SCALE_W;   // count * scale
    localparam int SCALE_SHIFT = 10;
    localparam int CH_W       = PROD_W - SCALE_SHIFT;
    localparam int COEF_W     = 10;
    localparam int MUL_W      = CH_W + COEF_W;
    localparam int QUO_W      = 11;                // quotient bits, 9 frac + round + 1
    localparam int RATIO_W    = QUO_W;
    localparam int LUX_FRAC   = 14;
    localparam int LUX_W      = 17;
    localparam int SEG_N      = 8;
    localparam int DIV_STEPS  = QUO_W - 1;         // first quotient bit is in stage 0

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SCALE_W;

    // queue sizes
    localparam int FQ_DEPTH   = 4;
    localparam int FQ_AW      = 2;
    localparam int OQ_DEPTH   = 16;
    localparam int OQ_AW      = 4;

    // result constants
    localparam logic [LUX_W-1:0] LUX_SAT = 17'd65536;
    localparam logic [LUX_W-1:0] LUX_MAX = 17'd131071;

    // register reset values
    localparam logic               PKG_RST   = 1'b0;
    localparam logic [CNT_W-1:0]   CLIP_RST  = 16'd4900;
    localparam logic [SCALE_W-1:0] SCALE_RST = 20'd479600;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PACKAGE = 2'd0,
        REG_CLIP    = 2'd1,
        REG_SCALE   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] broadband_count;
        logic [CNT_W-1:0] infrared_count;
    } t_lsl_in;

    typedef struct packed {
        logic [LUX_W-1:0] lux_value;
        logic             saturated;
    } t_lsl_out;

    typedef struct packed {
        logic               package_type;
        logic [CNT_W-1:0]   clip_threshold;
        logic [SCALE_W-1:0] channel_scale;
    } t_lsl_cfg;

    // classified and scaled item between front and back
    typedef struct packed {
        logic            sat;
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
    } t_lsl_mid;

    // coefficient tables: [package][segment]
    localparam logic [COEF_W-1:0] KNEE_TAB [2][SEG_N] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a}
    };
    localparam logic [COEF_W-1:0] ICPT_TAB [2][SEG_N] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
    };
    localparam logic [COEF_W-1:0] SLOPE_TAB [2][SEG_N] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
    };

endpackage

>>> design/lsl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsl_cfg: configuration register file
// Holds package select, clip threshold and channel scale; always ready.
// Writes to an index past the register list are dropped.
// ----------------------------------------------------------------------------
module lsl_cfg
    import lsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_lsl_cfg              o_cfg
);

    t_lsl_cfg r_cfg;
    t_lsl_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PACKAGE: n_cfg.package_type   = i_cfg_data[0];
                REG_CLIP:    n_cfg.clip_threshold = i_cfg_data[CNT_W-1:0];
                REG_SCALE:   n_cfg.channel_scale  = i_cfg_data[SCALE_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.package_type   <= PKG_RST;
            r_cfg.clip_threshold <= CLIP_RST;
            r_cfg.channel_scale  <= SCALE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> design/lsl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsl_front: intake, clip check and channel scaling
// Flags clipped measurements, scales both counts and queues the beat
// for the back end in a four-entry queue.
// ----------------------------------------------------------------------------
module lsl_front
    import lsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_lsl_in  i_item,
    input  t_lsl_cfg i_cfg,
    output logic     o_mid_valid,
    output t_lsl_mid o_mid,
    input  logic     i_mid_take
);

    t_lsl_mid         r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wr;
    logic [FQ_AW-1:0] r_rd;
    logic [FQ_AW:0]   r_cnt;
    logic [FQ_AW:0]   n_cnt;

    logic              push_ok;
    logic              take_ok;
    logic [PROD_W-1:0] prod0;
    logic [PROD_W-1:0] prod1;
    t_lsl_mid          mid_w;

    assign o_full      = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign o_mid_valid = (r_cnt != '0);
    assign o_mid       = r_mem[r_rd];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_mid_take && o_mid_valid;

    // classify and scale
    always_comb begin
        prod0     = PROD_W'(i_item.broadband_count) * PROD_W'(i_cfg.channel_scale);
        prod1     = PROD_W'(i_item.infrared_count) * PROD_W'(i_cfg.channel_scale);
        mid_w.sat = (i_item.broadband_count > i_cfg.clip_threshold) ||
                    (i_item.infrared_count > i_cfg.clip_threshold);
        mid_w.ch0 = prod0[PROD_W-1:SCALE_SHIFT];
        mid_w.ch1 = prod1[PROD_W-1:SCALE_SHIFT];
    end

    // queue occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !take_ok) n_cnt = r_cnt + 1'b1;
        if (!push_ok && take_ok) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) r_wr <= r_wr + 1'b1;
            if (take_ok) r_rd <= r_rd + 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr] <= mid_w;
    end

endmodule

>>> design/lsl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsl_back: ratio division, segment lookup and lux evaluation
// Restoring divider one quotient bit per stage, then coefficient pick,
// two multiplies and rounding. Results land in a 16-entry output queue;
// beats enter only while the queue has room for everything in flight.
// ----------------------------------------------------------------------------
module lsl_back
    import lsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_mid_valid,
    input  t_lsl_mid i_mid,
    output logic     o_mid_take,
    input  logic     i_pkg_sel,
    output logic     o_empty,
    output t_lsl_out o_result,
    input  logic     i_pop
);

    // credit over pipeline plus output queue
    logic [OQ_AW:0] r_credit;
    logic [OQ_AW:0] n_credit;
    logic           pop_ok;

    // divider stages
    logic             r_dv   [DIV_STEPS+1];
    logic             r_dsat [DIV_STEPS+1];
    logic             r_dzr  [DIV_STEPS+1];
    logic             r_dovf [DIV_STEPS+1];
    logic [CH_W-1:0]  r_dch0 [DIV_STEPS+1];
    logic [CH_W-1:0]  r_dch1 [DIV_STEPS+1];
    logic [CH_W-1:0]  r_drem [DIV_STEPS+1];
    logic [QUO_W-1:0] r_dq   [DIV_STEPS+1];
    logic [CH_W-1:0]  n_drem [DIV_STEPS+1];
    logic [QUO_W-1:0] n_dq   [DIV_STEPS+1];
    logic [CH_W:0]    rem2   [DIV_STEPS+1];
    logic             ge     [DIV_STEPS+1];
    logic             in_zr;
    logic             in_ovf;

    // segment stage
    logic              r_sv;
    logic              r_ssat;
    logic [CH_W-1:0]   r_sch0;
    logic [CH_W-1:0]   r_sch1;
    logic [COEF_W-1:0] r_sb;
    logic [COEF_W-1:0] r_sm;
    logic [QUO_W:0]    q_inc;
    logic [RATIO_W-1:0] ratio;
    logic              found;
    logic [COEF_W-1:0] n_sb;
    logic [COEF_W-1:0] n_sm;

    // multiply stage
    logic             r_mv;
    logic             r_msat;
    logic [MUL_W-1:0] r_mp0;
    logic [MUL_W-1:0] r_mp1;

    // final arithmetic
    logic [MUL_W-1:0]          diff;
    logic [MUL_W:0]            rnd;
    logic [MUL_W-LUX_FRAC:0]   shr;
    t_lsl_out                  res_w;

    // output queue
    t_lsl_out         r_oq   [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wr;
    logic [OQ_AW-1:0] r_oq_rd;
    logic [OQ_AW:0]   r_oq_cnt;
    logic [OQ_AW:0]   n_oq_cnt;

    assign o_mid_take = i_mid_valid && (r_credit < (OQ_AW+1)'(OQ_DEPTH));
    assign o_empty    = (r_oq_cnt == '0);
    assign o_result   = r_oq[r_oq_rd];
    assign pop_ok     = i_pop && !o_empty;

    always_comb begin
        n_credit = r_credit;
        if (o_mid_take && !pop_ok) n_credit = r_credit + 1'b1;
        if (!o_mid_take && pop_ok) n_credit = r_credit - 1'b1;
    end

    // first quotient bit and overflow check (ratio of two or more is off table)
    assign in_zr  = (i_mid.ch0 == '0);
    assign in_ovf = ({1'b0, i_mid.ch1} >= {i_mid.ch0, 1'b0});

    always_comb begin
        rem2[0]   = {1'b0, i_mid.ch1};
        ge[0]     = (i_mid.ch1 >= i_mid.ch0);
        n_drem[0] = ge[0] ? (i_mid.ch1 - i_mid.ch0) : i_mid.ch1;
        n_dq[0]   = QUO_W'(ge[0]);
        for (int k = 1; k <= DIV_STEPS; k++) begin
            rem2[k]   = {r_drem[k-1], 1'b0};
            ge[k]     = (rem2[k] >= {1'b0, r_dch0[k-1]});
            n_drem[k] = ge[k] ? CH_W'(rem2[k] - {1'b0, r_dch0[k-1]})
                              : rem2[k][CH_W-1:0];
            n_dq[k]   = {r_dq[k-1][QUO_W-2:0], ge[k]};
        end
    end

    // divider valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_dv[k] <= 1'b0;
        end else begin
            r_dv[0] <= o_mid_take;
            for (int k = 1; k <= DIV_STEPS; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    // divider payload
    always_ff @(posedge i_clk) begin
        r_dsat[0] <= i_mid.sat;
        r_dzr[0]  <= in_zr;
        r_dovf[0] <= in_ovf;
        r_dch0[0] <= i_mid.ch0;
        r_dch1[0] <= i_mid.ch1;
        r_drem[0] <= n_drem[0];
        r_dq[0]   <= n_dq[0];
        for (int k = 1; k <= DIV_STEPS; k++) begin
            r_dsat[k] <= r_dsat[k-1];
            r_dzr[k]  <= r_dzr[k-1];
            r_dovf[k] <= r_dovf[k-1];
            r_dch0[k] <= r_dch0[k-1];
            r_dch1[k] <= r_dch1[k-1];
            r_drem[k] <= n_drem[k];
            r_dq[k]   <= n_dq[k];
        end
    end

    // round ratio and pick the first segment whose knee covers it
    always_comb begin
        q_inc = {1'b0, r_dq[DIV_STEPS]} + 1'b1;
        ratio = r_dzr[DIV_STEPS] ? '0 : q_inc[QUO_W:1];
        found = 1'b0;
        n_sb  = '0;
        n_sm  = '0;
        if (r_dzr[DIV_STEPS] || !r_dovf[DIV_STEPS]) begin
            for (int i = 0; i < SEG_N; i++) begin
                if (!found && (ratio <= RATIO_W'(KNEE_TAB[i_pkg_sel][i]))) begin
                    found = 1'b1;
                    n_sb  = ICPT_TAB[i_pkg_sel][i];
                    n_sm  = SLOPE_TAB[i_pkg_sel][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_mv <= 1'b0;
        end else begin
            r_sv <= r_dv[DIV_STEPS];
            r_mv <= r_sv;
        end
    end

    // segment and multiply payload
    always_ff @(posedge i_clk) begin
        r_ssat <= r_dsat[DIV_STEPS];
        r_sch0 <= r_dch0[DIV_STEPS];
        r_sch1 <= r_dch1[DIV_STEPS];
        r_sb   <= n_sb;
        r_sm   <= n_sm;
        r_msat <= r_ssat;
        r_mp0  <= MUL_W'(r_sch0) * MUL_W'(r_sb);
        r_mp1  <= MUL_W'(r_sch1) * MUL_W'(r_sm);
    end

    // clamp difference, round, scale down, limit to field range
    always_comb begin
        diff = (r_mp0 > r_mp1) ? (r_mp0 - r_mp1) : '0;
        rnd  = {1'b0, diff} + (MUL_W+1)'(1 << (LUX_FRAC - 1));
        shr  = rnd[MUL_W:LUX_FRAC];
        if (r_msat) begin
            res_w.lux_value = LUX_SAT;
            res_w.saturated = 1'b1;
        end else begin
            res_w.lux_value = (shr > (MUL_W-LUX_FRAC+1)'(LUX_MAX)) ? LUX_MAX
                                                                  : shr[LUX_W-1:0];
            res_w.saturated = 1'b0;
        end
    end

    // output queue
    always_comb begin
        n_oq_cnt = r_oq_cnt;
        if (r_mv && !pop_ok) n_oq_cnt = r_oq_cnt + 1'b1;
        if (!r_mv && pop_ok) n_oq_cnt = r_oq_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            r_credit <= n_credit;
            r_oq_cnt <= n_oq_cnt;
            if (r_mv)   r_oq_wr <= r_oq_wr + 1'b1;
            if (pop_ok) r_oq_rd <= r_oq_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mv) r_oq[r_oq_wr] <= res_w;
    end

endmodule

>>> design/light_sensor_lux_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_lux_calc: two-channel ratio lux calculator
// Queue-style top level joining config registers, front end and back end.
// ----------------------------------------------------------------------------
// One measurement (broadband and infrared counts) is taken per clock on
// push while full is low, and one result per measurement comes out in order,
// shown while empty is low and removed on pop. Sustained rate is one item
// per cycle while results are popped; an accepted beat first waits in the
// intake queue, then passes the eleven-stage restoring divider that
// forms the channel ratio, then the lookup, multiply and output queue
// stages. A four-entry queue sits between intake and math, and a
// sixteen-entry output queue absorbs stalls on the result side.
// Configuration writes are taken every cycle and must only happen while
// the block holds no work.
module light_sensor_lux_calc
    import lsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_lsl_in               i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_lsl_out              o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_lsl_cfg cfg;
    t_lsl_mid mid;
    logic     mid_valid;
    logic     mid_take;

    lsl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_cfg       (cfg),
        .o_mid_valid (mid_valid),
        .o_mid       (mid),
        .i_mid_take  (mid_take)
    );

    lsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_mid_take  (mid_take),
        .i_pkg_sel   (cfg.package_type),
        .o_empty     (empty),
        .o_result    (o_result),
        .i_pop       (pop)
    );

endmodule

>>> design/lsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsl_checker: port-level checks for the lux calculator
// Watches the queue-style ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module lsl_checker
    import lsl_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     push,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input t_lsl_out o_result
);

    // both queues come out of reset drained
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // a clipped beat always reports the fixed saturation value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.saturated) |-> (o_result.lux_value == LUX_SAT))
        else $error("saturated result with wrong lux value");

    // intake only fills up from an accepted beat
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // a waiting result is held until popped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind light_sensor_lux_calc lsl_checker u_lsl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

>>> tb/light_sensor_lux_calc_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_lux_calc_test: self-checking bench for the lux calculator
// Feeds measurements through the push/full side while popping results at a
// random pace. A scoreboard predicts lux and the saturated flag from its own
// copy of the registers and compares each result, in order, field by field.
// ----------------------------------------------------------------------------
module light_sensor_lux_calc_test;
    import lsl_pkg::*;

    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
    localparam int HOLD_AT      = 150;   // results seen before the hold-off
    localparam int WDOG_LIMIT   = 3000;
    localparam int N_DIRECTED   = 12;

    // directed measurements: zero broadband, clip edges, knee edges, tiny counts
    localparam logic [CNT_W-1:0] DIR_BB [N_DIRECTED] = '{
        16'd0, 16'd0, 16'd4900, 16'd4901, 16'd0, 16'd65535,
        16'd4000, 16'd1000, 16'd1024, 16'd1024, 16'd1, 16'd65535
    };
    localparam logic [CNT_W-1:0] DIR_IR [N_DIRECTED] = '{
        16'd0, 16'd100, 16'd4900, 16'd0, 16'd4901, 16'd65535,
        16'd0, 16'd1400, 16'd128, 16'd129, 16'd1, 16'd0
    };

    // coefficient tables per package: knee, intercept, slope
    localparam logic [9:0] KNEE [2][SEG_N] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a}
    };
    localparam logic [9:0] ICPT [2][SEG_N] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
    };
    localparam logic [9:0] SLOPE [2][SEG_N] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
    };

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, lux prediction, in-order result check
    // ------------------------------------------------------------------------
    class lux_scoreboard;
        logic               pkg_sel;
        logic [CNT_W-1:0]   clip;
        logic [SCALE_W-1:0] scale;
        t_lsl_out           expected_lux[$];
        int                 errors;

        function new();
            pkg_sel = PKG_RST;
            clip    = CLIP_RST;
            scale   = SCALE_RST;
            errors  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PACKAGE: pkg_sel = data[0];
                REG_CLIP:    clip    = data[CNT_W-1:0];
                REG_SCALE:   scale   = data;
                default: ;
            endcase
        endfunction

        function t_lsl_out calc_lux(t_lsl_in m);
            logic [63:0] ch0;
            logic [63:0] ch1;
            logic [63:0] ratio;
            logic [63:0] icpt_v;
            logic [63:0] slope_v;
            logic [63:0] diff;
            logic [63:0] lux;
            t_lsl_out    r;
            bit          found;
            r = '0;
            // clipped channel: fixed saturation code
            if (m.broadband_count > clip || m.infrared_count > clip) begin
                r.lux_value = LUX_SAT;
                r.saturated = 1'b1;
                return r;
            end
            ch0 = (64'(m.broadband_count) * 64'(scale)) >> SCALE_SHIFT;
            ch1 = (64'(m.infrared_count) * 64'(scale)) >> SCALE_SHIFT;
            // rounded ratio, 9 fraction bits; zero broadband gives zero
            ratio = '0;
            if (ch0 != 0)
                ratio = (ch1 << 10) / ch0;
            ratio = (ratio + 1) >> 1;
            // first segment whose knee is not below the ratio
            icpt_v  = '0;
            slope_v = '0;
            found   = 1'b0;
            for (int s = 0; s < SEG_N; s++) begin
                if (!found && ratio <= 64'(KNEE[pkg_sel][s])) begin
                    icpt_v  = 64'(ICPT[pkg_sel][s]);
                    slope_v = 64'(SLOPE[pkg_sel][s]);
                    found   = 1'b1;
                end
            end
            ch0  = ch0 * icpt_v;
            ch1  = ch1 * slope_v;
            diff = (ch0 > ch1) ? ch0 - ch1 : 64'd0;
            lux  = (diff + (64'd1 << (LUX_FRAC - 1))) >> LUX_FRAC;
            if (lux > 64'(LUX_MAX))
                lux = 64'(LUX_MAX);
            r.lux_value = lux[LUX_W-1:0];
            return r;
        endfunction

        function void note_input(t_lsl_in m);
            expected_lux.push_back(calc_lux(m));
        endfunction

        function void check_result(t_lsl_out got);
            t_lsl_out want;
            if (expected_lux.size() == 0) begin
                $display("%0t: unexpected result lux=%0d sat=%0b", $time,
                         got.lux_value, got.saturated);
                errors++;
                return;
            end
            want = expected_lux.pop_front();
            if (got.lux_value !== want.lux_value) begin
                $display("%0t: lux_value mismatch: expected %0d actual %0d", $time,
                         want.lux_value, got.lux_value);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated mismatch: expected %0b actual %0b", $time,
                         want.saturated, got.saturated);
                errors++;
            end
        endfunction

        function int pending();
            return expected_lux.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_lsl_in               i_item;
    logic                  empty;
    logic                  pop;
    t_lsl_out              o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lux_scoreboard sb = new();
    int            tx_burst;

    light_sensor_lux_calc DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // gap length: mostly none or short, a few long, with gap-free bursts
    function automatic int pick_gap(inout int burst_left);
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // count near the clip threshold or at a field extreme
    function automatic logic [CNT_W-1:0] pick_corner(int clip);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CNT_W'(clip);
            2:       return CNT_W'(clip + 1);
            3:       return '1;
            default: return CNT_W'($urandom_range(0, clip));
        endcase
    endfunction

    // mostly unclipped pairs with the ratio spread over all segments
    function automatic t_lsl_in rand_measurement(int clip);
        t_lsl_in m;
        int      sel;
        int      bb;
        int      ir;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            m.broadband_count = CNT_W'($urandom);
            m.infrared_count  = CNT_W'($urandom);
        end else if (sel < 35) begin
            m.broadband_count = pick_corner(clip);
            m.infrared_count  = pick_corner(clip);
        end else begin
            if (sel < 45)
                bb = $urandom_range(0, 63);
            else
                bb = $urandom_range(0, clip);
            ir = bb * $urandom_range(0, 800) / 512 + $urandom_range(0, 2);
            if (ir > 65535)
                ir = 65535;
            m.broadband_count = CNT_W'(bb);
            m.infrared_count  = CNT_W'(ir);
        end
        return m;
    endfunction

    // one input beat, after a random gap
    task automatic send_measurement(t_lsl_in m);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= m;
        do @(posedge i_clk); while (full);
        sb.note_input(m);
    endtask

    // write all three registers back to back; block must be idle
    task automatic load_regs(logic pkg_v, logic [CNT_W-1:0] clip_v,
                             logic [SCALE_W-1:0] scale_v);
        t_reg_idx              idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{REG_PACKAGE, REG_CLIP, REG_SCALE};
        val = '{CFG_DATA_W'(pkg_v), CFG_DATA_W'(clip_v), scale_v};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // directed list (optional), random items, then drain to idle
    task automatic run_phase(bit with_directed);
        t_lsl_in m;
        if (with_directed) begin
            for (int i = 0; i < N_DIRECTED; i++) begin
                m.broadband_count = DIR_BB[i];
                m.infrared_count  = DIR_IR[i];
                send_measurement(m);
            end
        end
        repeat (PHASE_ITEMS) send_measurement(rand_measurement(int'(sb.clip)));
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // main sequence: reset, then phases over several register settings
    initial begin : stimulus
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_PACKAGE;
        i_cfg_data  <= '0;
        tx_burst = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(1'b1);                               // reset values
        load_regs(1'b1, 16'd4900, 20'd479600);          // CS table
        run_phase(1'b0);
        load_regs(1'b1, 16'hffff, 20'hfffff);           // no clipping, lux overflow
        run_phase(1'b1);
        load_regs(1'b0, 16'd0, 20'd479600);             // nearly all clipped
        run_phase(1'b0);
        load_regs(1'b0, 16'hffff, 20'd0);               // zero scale
        run_phase(1'b0);
        repeat (2) begin
            load_regs(1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 65535)),
                      SCALE_W'($urandom_range(0, 1048575)));
            run_phase(1'b0);
        end
        load_regs(1'b0, 16'hffff, 20'd1);               // smallest nonzero scale
        run_phase(1'b0);

        if (sb.errors == 0)
            $display("light_sensor_lux_calc_test OK");
        else
            $display("light_sensor_lux_calc_test NOT OK");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial begin : result_sink
        int stall_left;
        int rx_burst;
        int results_seen;
        bit held;
        stall_left   = 0;
        rx_burst     = 0;
        results_seen = 0;
        held         = 1'b0;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.check_result(o_result);
                results_seen++;
            end
            if (!held && results_seen >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                stall_left = pick_gap(rx_burst);
                if (stall_left > 0) begin
                    stall_left--;
                    pop <= 1'b0;
                end else begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // watchdog: cycles in a row with no beat on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("%0t: timeout, no beat for %0d cycles", $time, quiet);
                $display("light_sensor_lux_calc_test NOT OK");
                $finish;
            end
        end
    end

endmodule
